[sv/sus_pkg.sv]
// ----------------------------------------------------------------------------
// sus_pkg: shared types and constants for the sorted unique set
// Word formats, status and operation codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package sus_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 6;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DPREP,
    S_DUMP
  } state_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] element;
    logic                      element_valid;
    logic                      last;
  } rsp_t;

  // compare result of a stored word against the request value
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

  // one dump word handed to the output register
  typedef struct packed {
    logic load;
    rsp_t data;
  } dump_t;

endpackage

`default_nettype wire

[sv/sus_ram.sv]
// ----------------------------------------------------------------------------
// sus_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data, no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/sus_cmp.sv]
// ----------------------------------------------------------------------------
// sus_cmp: signed word comparator
// Compares one stored word against the request value, signed 32-bit.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_cmp
  import sus_pkg::*;
(
  input  wire logic        [VALUE_W-1:0] a,
  input  wire logic signed [VALUE_W-1:0] b,
  output cmp_t                           res
);

  // compare as two's complement
  always_comb begin
    res.lt = $signed(a) < b;
    res.eq = $signed(a) == b;
  end

endmodule

`default_nettype wire

[sv/sus_ctrl.sv]
// ----------------------------------------------------------------------------
// sus_ctrl: request sequencer for the sorted unique set
// Scans the store once per request, shifting entries while it goes, then
// dumps the store in order through the shared RAM read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_ctrl
  import sus_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire req_t               req,
  output logic                    req_stall,
  input  wire logic               out_free,
  output dump_t                   dump,
  output logic                    we,
  output logic [AW-1:0]           waddr,
  output logic [VALUE_W-1:0]      wdata,
  output logic [AW-1:0]           raddr,
  input  wire logic [VALUE_W-1:0] rdata
);

  state_t                    state, state_next;
  kind_t                     kind;
  logic signed [VALUE_W-1:0] value;
  logic [CW-1:0]             cnt, cnt_next;
  logic [CW-1:0]             idx, idx_next;
  logic                      hit, hit_next;
  logic [VALUE_W-1:0]        carry, carry_next;
  status_t                   status, status_next;

  logic                      finish;
  logic                      at_end;
  logic                      full;
  logic                      last_now;
  logic [CW-1:0]             idx_p1;
  logic [CW-1:0]             idx_m1;
  logic [CW+COUNT_W-1:0]     cnt_ext;
  cmp_t                      cmp;

  sus_cmp u_cmp (
    .a   (rdata),
    .b   (value),
    .res (cmp)
  );

  assign idx_p1    = idx + CW'(1);
  assign idx_m1    = idx - CW'(1);
  assign at_end    = (idx == cnt);
  assign full      = (cnt == CW'(CAPACITY));
  assign last_now  = (cnt == '0) || (idx_p1 == cnt);
  assign cnt_ext   = (CW + COUNT_W)'(cnt);
  assign req_stall = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (finish) state_next = S_DPREP;
      end
      S_DPREP: begin
        state_next = S_DUMP;
      end
      S_DUMP: begin
        if (out_free && last_now) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath control: RAM ports, scan decisions, dump words
  always_comb begin
    we          = 1'b0;
    waddr       = idx[AW-1:0];
    wdata       = carry;
    raddr       = '0;
    finish      = 1'b0;
    cnt_next    = cnt;
    idx_next    = idx;
    hit_next    = hit;
    carry_next  = carry;
    status_next = status;
    dump        = '0;
    case (state)
      S_IDLE: begin
        idx_next = '0;
        hit_next = 1'b0;
      end
      S_SCAN: begin
        raddr    = idx_p1[AW-1:0];
        idx_next = idx_p1;
        if (kind == KIND_INSERT) begin
          if (at_end) begin
            finish = 1'b1;
            if (hit) begin
              we          = 1'b1;
              cnt_next    = cnt + CW'(1);
              status_next = ST_DONE;
            end else if (full) begin
              status_next = ST_FULL;
            end else begin
              we          = 1'b1;
              wdata       = value;
              cnt_next    = cnt + CW'(1);
              status_next = ST_DONE;
            end
          end else if (hit) begin
            // shift one slot up
            we         = 1'b1;
            carry_next = rdata;
          end else if (cmp.eq) begin
            finish      = 1'b1;
            status_next = ST_REFUSED;
          end else if (!cmp.lt) begin
            if (full) begin
              finish      = 1'b1;
              status_next = ST_FULL;
            end else begin
              we         = 1'b1;
              wdata      = value;
              carry_next = rdata;
              hit_next   = 1'b1;
            end
          end
        end else begin
          if (at_end) begin
            finish = 1'b1;
            if (hit) begin
              cnt_next    = cnt - CW'(1);
              status_next = ST_DONE;
            end else begin
              status_next = ST_REFUSED;
            end
          end else if (hit) begin
            // shift one slot down
            we    = 1'b1;
            waddr = idx_m1[AW-1:0];
            wdata = rdata;
          end else if (cmp.eq) begin
            hit_next = 1'b1;
          end else if (!cmp.lt) begin
            finish      = 1'b1;
            status_next = ST_REFUSED;
          end
        end
        if (finish) idx_next = '0;
      end
      S_DPREP: begin
        raddr    = '0;
        idx_next = '0;
      end
      S_DUMP: begin
        raddr = idx[AW-1:0];
        if (out_free) begin
          dump.load               = 1'b1;
          dump.data.status        = status;
          dump.data.count         = cnt_ext[COUNT_W-1:0];
          dump.data.element       = (cnt == '0) ? '0 : $signed(rdata);
          dump.data.element_valid = (cnt != '0);
          dump.data.last          = last_now;
          raddr                   = idx_p1[AW-1:0];
          idx_next                = idx_p1;
        end
      end
      default: begin
        idx_next = '0;
      end
    endcase
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      idx   <= '0;
      hit   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
      hit   <= hit_next;
    end
  end

  // capture request and scan payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      kind  <= req.kind;
      value <= req.value;
    end
    carry  <= carry_next;
    status <= status_next;
  end

  // writes happen only during the scan
  assert property (@(posedge clk) disable iff (rst) we |-> state == S_SCAN)
    else $error("store written outside scan");

  // count stays within capacity
  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(CAPACITY))
    else $error("count above capacity");

  // the last dump word returns the sequencer to idle
  assert property (@(posedge clk) disable iff (rst)
    dump.load && dump.data.last |=> state == S_IDLE)
    else $error("no return to idle after last word");

  // an empty store dumps one word with no element
  assert property (@(posedge clk) disable iff (rst)
    dump.load && !dump.data.element_valid |-> dump.data.last && cnt == '0)
    else $error("empty dump word malformed");

  // an accepted request starts a scan
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == S_SCAN)
    else $error("accepted request did not start scan");

endmodule

`default_nettype wire

[sv/sorted_unique_set.sv]
// ----------------------------------------------------------------------------
// sorted_unique_set: bounded ascending set of distinct signed words
// Sequence: the request is captured in idle, the store is scanned in S_SCAN,
//   S_DPREP sets up the first read, and S_DUMP hands out the words in order.
// Requests: no new request is taken until the last dump word of the previous
//   one is loaded, and the dump waits while the output stalls; one RAM read port
//   serves scan and dump.
// Reset: count cleared, sequencer idle, output empty; entries undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set
  import sus_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] rdata;
  logic               out_free;
  dump_t              dump;

  sus_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  sus_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .out_free  (out_free),
    .dump      (dump),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  assign out_free = !rsp_valid || !rsp_stall;

  // hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (dump.load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dump.load) begin
      rsp <= dump.data;
    end
  end

endmodule

`default_nettype wire

[tb/sorted_unique_set_tb.sv]
// ----------------------------------------------------------------------------
// sorted_unique_set_tb: self-checking bench for the sorted unique set
// Drives insert and delete requests through a bursty driver, keeps a shadow
// sorted set to predict every dump word, and checks each returned word field
// by field while the output side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set_tb;
  import sus_pkg::*;

  typedef struct {
    req_t req;
    bit   drain_first;  // hold this word until every dump word has come back
  } pending_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  pending_t                  pending_reqs[$];
  rsp_t                      expected_words[$];
  logic signed [VALUE_W-1:0] held_vals[$];     // shadow set, ascending
  logic signed [VALUE_W-1:0] value_pool[48];

  int mismatches    = 0;
  int accepted_reqs = 0;
  int burst_left    = 1;
  int gap_left      = 0;
  int stall_mode    = 0;
  int mode_left     = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  sorted_unique_set #(
    .CAPACITY (CAPACITY_DEF)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Update the shadow set for one accepted request and queue its dump words.
  function automatic void apply_request(req_t r);
    int      pos;
    bit      present;
    status_t st;
    rsp_t    w;
    pos = 0;
    while (pos < held_vals.size() && $signed(held_vals[pos]) < $signed(r.value))
      pos++;
    present = (pos < held_vals.size()) && (held_vals[pos] == r.value);
    if (r.kind == KIND_INSERT) begin
      if (present) begin
        st = ST_REFUSED;
      end else if (held_vals.size() >= CAPACITY_DEF) begin
        st = ST_FULL;
      end else begin
        held_vals.insert(pos, r.value);
        st = ST_DONE;
      end
    end else begin
      if (!present) begin
        st = ST_REFUSED;
      end else begin
        held_vals.delete(pos);
        st = ST_DONE;
      end
    end
    // empty store still answers with a single word carrying no element
    if (held_vals.size() == 0) begin
      w.status        = st;
      w.count         = '0;
      w.element       = '0;
      w.element_valid = 1'b0;
      w.last          = 1'b1;
      expected_words.push_back(w);
    end else begin
      for (int i = 0; i < held_vals.size(); i++) begin
        w.status        = st;
        w.count         = COUNT_W'(held_vals.size());
        w.element       = held_vals[i];
        w.element_valid = 1'b1;
        w.last          = (i == held_vals.size() - 1);
        expected_words.push_back(w);
      end
    end
  endfunction

  // Compare one returned word with the oldest predicted word.
  task automatic check_word(input rsp_t got);
    rsp_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word %h", got));
      return;
    end
    want = expected_words.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.count !== want.count)
      report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
    if (got.element !== want.element)
      report_mismatch($sformatf("element %0d, want %0d", got.element, want.element));
    if (got.element_valid !== want.element_valid)
      report_mismatch($sformatf("element_valid %b, want %b",
                                got.element_valid, want.element_valid));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %b, want %b", got.last, want.last));
  endtask

  task automatic push_req(input kind_t k, input logic [VALUE_W-1:0] v,
                          input bit drain);
    pending_t p;
    p.req.kind    = k;
    p.req.value   = v;
    p.drain_first = drain;
    pending_reqs.push_back(p);
  endtask

  // Driver: present words in bursts, hold a stalled word, advance on accept.
  always @(posedge clk) begin
    logic nxt_valid;
    req_t nxt_req;
    nxt_valid = req_valid;
    nxt_req   = req;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        apply_request(req);
        accepted_reqs++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain_first && expected_words.size() != 0)) begin
          nxt_req   = pending_reqs[0].req;
          nxt_valid = 1'b1;
          pending_reqs.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // mostly short bursts, now and then a long stretch with no gaps
            if ($urandom_range(0, 5) == 0) begin
              burst_left = $urandom_range(20, 40);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 8);
              gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                       : $urandom_range(0, 5);
            end
          end
        end
      end
    end
    req_valid <= nxt_valid;
    req       <= nxt_req;
  end

  // Monitor: check accepted words and pick the next stall value.
  always @(posedge clk) begin
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (!rst) begin
      if (rsp_valid && !rsp_stall)
        check_word(rsp);
      // one long hold-off while the sender keeps offering
      if (!hold_done && accepted_reqs >= 100) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: nxt_stall = 1'b0;
          1: nxt_stall = ($urandom_range(0, 2) == 0);
          default: nxt_stall = ~rsp_stall;
        endcase
      end
    end
    rsp_stall <= nxt_stall;
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [VALUE_W-1:0] v;
    kind_t              k;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    value_pool[5] = 32'h8000_0001;
    value_pool[6] = 32'h7fff_fffe;
    for (int i = 7; i < 48; i++)
      value_pool[i] = (i % 3 == 0) ? VALUE_W'($urandom_range(0, 200)) - 100 : $urandom;

    // directed: empty store, duplicates, absent deletes, extremes of value
    push_req(KIND_DELETE, 32'd5, 1'b0);
    push_req(KIND_INSERT, 32'd0, 1'b0);
    push_req(KIND_INSERT, 32'd0, 1'b0);
    push_req(KIND_INSERT, 32'h8000_0000, 1'b0);
    push_req(KIND_INSERT, 32'h7fff_ffff, 1'b0);
    push_req(KIND_INSERT, 32'hffff_ffff, 1'b0);
    push_req(KIND_INSERT, 32'h0000_0001, 1'b0);
    push_req(KIND_DELETE, 32'd0, 1'b0);
    push_req(KIND_DELETE, 32'd0, 1'b0);
    push_req(KIND_INSERT, 32'h5555_5555, 1'b0);
    push_req(KIND_INSERT, 32'haaaa_aaaa, 1'b0);
    push_req(KIND_DELETE, 32'h7fff_ffff, 1'b0);
    push_req(KIND_DELETE, 32'h8000_0000, 1'b0);
    push_req(KIND_DELETE, 32'hffff_ffff, 1'b0);
    push_req(KIND_DELETE, 32'h0000_0001, 1'b0);
    push_req(KIND_DELETE, 32'h5555_5555, 1'b0);
    push_req(KIND_DELETE, 32'haaaa_aaaa, 1'b0);

    // fill toward capacity, then keep inserting into a full store
    for (int i = 0; i < 80; i++) begin
      k = ($urandom_range(0, 99) < ((i < 60) ? 85 : 92)) ? KIND_INSERT : KIND_DELETE;
      push_req(k, value_pool[$urandom_range(0, 47)], 1'b0);
    end
    // drain: delete every pool value, a few inserts mixed in
    for (int i = 0; i < 48; i++) begin
      push_req(KIND_DELETE, value_pool[i], i == 0);
      if ($urandom_range(0, 7) == 0)
        push_req(KIND_INSERT, value_pool[$urandom_range(0, 47)], 1'b0);
    end
    for (int i = 0; i < 48; i++)
      push_req(KIND_DELETE, value_pool[i], 1'b0);
    // mixed traffic, half from the pool and half wide random values
    for (int i = 0; i < 30; i++) begin
      k = ($urandom_range(0, 2) == 0) ? KIND_DELETE : KIND_INSERT;
      v = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 47)] : $urandom;
      push_req(k, v, i == 15);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid)
      @(posedge clk);
    while (expected_words.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
sv/sus_pkg.sv
sv/sus_ram.sv
sv/sus_cmp.sv
sv/sus_ctrl.sv
sv/sorted_unique_set.sv
tb/sorted_unique_set_tb.sv
